// File: rtl/bfma_pkg.sv
// Shared constants, types and the arctangent table for the flow moment accumulator.
package bfma_pkg;

    localparam int COLS_PER_HARMONIC = 4;
    localparam int BASE_COLS         = 3;
    localparam int COUNT_COL         = 5;
    localparam int FIRST_HARM_COL    = 7;
    localparam int CORDIC_STEPS      = 16;
    localparam int ANGLE_W           = 16;
    localparam int TRIG_W            = 18;
    localparam int ZANG_W            = 17;

    localparam logic signed [TRIG_W-1:0] CORDIC_START = 18'sd9949;
    localparam logic [ANGLE_W-1:0]       QUARTER_HALF = 16'd8192;

    localparam logic [2:0] REG_PT_MIN      = 3'd0;
    localparam logic [2:0] REG_PT_WIDTH    = 3'd1;
    localparam logic [2:0] REG_PT_BINS     = 3'd2;
    localparam logic [2:0] REG_Y_MIN       = 3'd3;
    localparam logic [2:0] REG_Y_WIDTH     = 3'd4;
    localparam logic [2:0] REG_Y_BINS      = 3'd5;
    localparam logic [2:0] REG_ORDERS      = 3'd6;
    localparam logic [2:0] REG_RAPIDITY    = 3'd7;

    localparam logic [1:0] SUB_COS    = 2'd0;
    localparam logic [1:0] SUB_SIN    = 2'd1;
    localparam logic [1:0] SUB_COS_SQ = 2'd2;
    localparam logic [1:0] SUB_SIN_SQ = 2'd3;

    typedef enum logic [10:0] {
        S_CLEAR  = 11'b000_0000_0001,
        S_IDLE   = 11'b000_0000_0010,
        S_DIV    = 11'b000_0000_0100,
        S_CHECK  = 11'b000_0000_1000,
        S_RD     = 11'b000_0001_0000,
        S_WR     = 11'b000_0010_0000,
        S_CORDIC = 11'b000_0100_0000,
        S_SQ     = 11'b000_1000_0000,
        S_RRD    = 11'b001_0000_0000,
        S_RDATA  = 11'b010_0000_0000,
        S_DONE   = 11'b100_0000_0000
    } t_state;

    function automatic logic signed [ZANG_W-1:0] arc_table(input logic [3:0] idx);
        logic signed [ZANG_W-1:0] v;
        unique case (idx)
            4'd0:  v = 17'sd8192;
            4'd1:  v = 17'sd4836;
            4'd2:  v = 17'sd2555;
            4'd3:  v = 17'sd1297;
            4'd4:  v = 17'sd651;
            4'd5:  v = 17'sd326;
            4'd6:  v = 17'sd163;
            4'd7:  v = 17'sd81;
            4'd8:  v = 17'sd41;
            4'd9:  v = 17'sd20;
            4'd10: v = 17'sd10;
            4'd11: v = 17'sd5;
            4'd12: v = 17'sd3;
            4'd13: v = 17'sd1;
            4'd14: v = 17'sd1;
            4'd15: v = 17'sd0;
            default: v = 17'sd0;
        endcase
        return v;
    endfunction

endpackage

// File: rtl/bfma_store.sv
// Single-port-write, registered-read memory that holds the histogram cells.
module bfma_store #(
    parameter int DEPTH = 8960,
    parameter int AW    = 14
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [63:0]   i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [63:0]   o_rdata
);

    logic [63:0] r_mem [DEPTH];
    logic [63:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/bfma_div.sv
// Two-lane restoring divider, one quotient bit per lane each cycle.
module bfma_div
    import bfma_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [1:0][15:0] i_num,
    input  logic [1:0][15:0] i_den,
    output logic             o_done,
    output logic [1:0][15:0] o_quo
);

    logic             r_busy;
    logic             r_done;
    logic [3:0]       r_step;
    logic [1:0][15:0] r_num;
    logic [1:0][15:0] r_den;
    logic [1:0][15:0] r_rem;
    logic [1:0][15:0] r_quo;
    logic [1:0][16:0] rem_sh;
    logic [1:0]       fits;

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            rem_sh[l] = {r_rem[l], r_num[l][15]};
            fits[l]   = rem_sh[l] >= {1'b0, r_den[l]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= r_busy && (r_step == 4'd15);
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 4'd1;
                if (r_step == 4'd15) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_busy) begin
            for (int l = 0; l < 2; l++) begin
                r_num[l] <= {r_num[l][14:0], 1'b0};
                r_quo[l] <= {r_quo[l][14:0], fits[l]};
                r_rem[l] <= fits[l] ? 16'(rem_sh[l] - {1'b0, r_den[l]}) : rem_sh[l][15:0];
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

// File: rtl/bfma_cordic.sv
// Iterative CORDIC that gives the Q14 cosine and sine of a binary angle.
module bfma_cordic
    import bfma_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [ANGLE_W-1:0]       i_angle,
    output logic                     o_done,
    output logic signed [TRIG_W-1:0] o_cos,
    output logic signed [TRIG_W-1:0] o_sin
);

    logic                     r_busy;
    logic                     r_done;
    logic [3:0]               r_step;
    logic [1:0]               r_quad;
    logic signed [TRIG_W-1:0] r_x;
    logic signed [TRIG_W-1:0] r_y;
    logic signed [ZANG_W-1:0] r_z;
    logic signed [TRIG_W-1:0] r_cos;
    logic signed [TRIG_W-1:0] r_sin;

    logic [ANGLE_W-1:0]       shifted;
    logic signed [TRIG_W-1:0] dx;
    logic signed [TRIG_W-1:0] dy;
    logic signed [TRIG_W-1:0] n_x;
    logic signed [TRIG_W-1:0] n_y;
    logic signed [ZANG_W-1:0] n_z;

    assign shifted = i_angle + QUARTER_HALF;

    always_comb begin
        dx = r_y >>> r_step;
        dy = r_x >>> r_step;
        if (!r_z[ZANG_W-1]) begin
            n_x = r_x - dx;
            n_y = r_y + dy;
            n_z = r_z - arc_table(r_step);
        end else begin
            n_x = r_x + dx;
            n_y = r_y - dy;
            n_z = r_z + arc_table(r_step);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= r_busy && (r_step == 4'd15);
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 4'd1;
                if (r_step == 4'd15) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quad <= shifted[15:14];
            r_x    <= CORDIC_START;
            r_y    <= '0;
            r_z    <= $signed({3'b000, shifted[13:0]}) - 17'sd8192;
        end else if (r_busy) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
            if (r_step == 4'd15) begin
                unique case (r_quad)
                    2'd0: begin
                        r_cos <= n_x;
                        r_sin <= n_y;
                    end
                    2'd1: begin
                        r_cos <= -n_y;
                        r_sin <= n_x;
                    end
                    2'd2: begin
                        r_cos <= -n_x;
                        r_sin <= -n_y;
                    end
                    default: begin
                        r_cos <= n_y;
                        r_sin <= -n_x;
                    end
                endcase
            end
        end
    end

    assign o_done = r_done;
    assign o_cos  = r_cos;
    assign o_sin  = r_sin;

endmodule

// File: rtl/binned_flow_moment_accumulator.sv
// Top level: register port, cell sequencer and output register of the flow histogram.
//
//  Channel   Direction  Handshake                     Payload
//  input     in         i_in_valid / o_in_ready       i_mode .. i_read_column
//  output    out        o_out_valid / i_out_ready     o_accepted, o_cell_value,
//                                                     o_particle_total
//  config    in         psel, penable, pwrite, pready paddr, pwdata, prdata
//
// After reset the block zeroes the histogram memory, one entry a cycle, all
// MAX_PT_BINS*MAX_Y_BINS*(4*MAX_ORDERS+3) entries (8960 by default), before it takes a beat.
// A fill beat runs the bin divider, then a read-modify-write of each column on the
// histogram memory, with a run of the iterative CORDIC before each harmonic's columns.
// A read beat reads the addressed cell and registers its value, and skips the read when
// its address is out of range.
// The next beat is taken while a result waits in the output register.
module binned_flow_moment_accumulator
    import bfma_pkg::*;
#(
    parameter int MAX_PT_BINS = 16,
    parameter int MAX_Y_BINS  = 16,
    parameter int MAX_ORDERS  = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_mode,
    input  logic [15:0]        i_pt,
    input  logic signed [14:0] i_pseudorapidity,
    input  logic signed [14:0] i_true_rapidity,
    input  logic [15:0]        i_azimuth,
    input  logic [15:0]        i_transverse_energy,
    input  logic [3:0]         i_read_pt_bin,
    input  logic [3:0]         i_read_y_bin,
    input  logic [5:0]         i_read_column,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_accepted,
    output logic signed [63:0] o_cell_value,
    output logic [31:0]        o_particle_total,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int CELL_COLS = COLS_PER_HARMONIC * MAX_ORDERS + BASE_COLS;
    localparam int DEPTH     = MAX_PT_BINS * MAX_Y_BINS * CELL_COLS;
    localparam int AW        = $clog2(DEPTH);
    localparam int CW        = $clog2(CELL_COLS + 1);

    logic [15:0]        r_pt_min;
    logic [15:0]        r_pt_width;
    logic [4:0]         r_pt_bins;
    logic signed [14:0] r_y_min;
    logic [14:0]        r_y_width;
    logic [4:0]         r_y_bins;
    logic [3:0]         r_orders;
    logic               r_rap_sel;

    t_state             r_state;
    t_state             n_state;
    logic [AW-1:0]      r_clr;
    logic               r_mode;
    logic [15:0]        r_pt;
    logic signed [14:0] r_y;
    logic [15:0]        r_phi;
    logic [15:0]        r_et;
    logic [15:0]        r_angle;
    logic               r_neg;
    logic               r_hit;
    logic [AW-1:0]      r_cell_base;
    logic [CW-1:0]      r_col;
    logic [1:0]         r_sub;
    logic [31:0]        r_pt_sq;
    logic [29:0]        r_y_sq;
    logic signed [TRIG_W-1:0] r_c;
    logic signed [TRIG_W-1:0] r_s;
    logic [35:0]        r_c_sq;
    logic [35:0]        r_s_sq;
    logic [63:0]        r_value;
    logic [31:0]        r_count;
    logic               r_out_valid;
    logic               r_out_accepted;
    logic [63:0]        r_out_value;
    logic [31:0]        r_out_total;

    logic               cfg_wr;
    logic               in_fire;
    logic               out_free;
    logic [8:0]         npt;
    logic [8:0]         ny;
    logic [4:0]         orders;
    logic [CW-1:0]      ncols;
    logic [16:0]        d_pt;
    logic signed [15:0] y_sel;
    logic signed [15:0] d_y;
    logic               div_start;
    logic               div_done;
    logic [1:0][15:0]   div_num;
    logic [1:0][15:0]   div_den;
    logic [1:0][15:0]   div_quo;
    logic               cor_start;
    logic               cor_done;
    logic [15:0]        next_angle;
    logic signed [TRIG_W-1:0] cor_cos;
    logic signed [TRIG_W-1:0] cor_sin;
    logic [CW-1:0]      col_next;
    logic               new_harm;
    logic               fill_hit;
    logic [AW-1:0]      mem_addr;
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [63:0]        mem_wdata;
    logic [63:0]        mem_rdata;
    logic [63:0]        addv;
    logic [31:0]        n_count;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pt_min   <= 16'd0;
            r_pt_width <= 16'd256;
            r_pt_bins  <= 5'd16;
            r_y_min    <= -15'sd8192;
            r_y_width  <= 15'd1024;
            r_y_bins   <= 5'd16;
            r_orders   <= 4'd8;
            r_rap_sel  <= 1'b0;
        end else if (cfg_wr) begin
            unique case (paddr[4:2])
                REG_PT_MIN:   r_pt_min   <= pwdata[15:0];
                REG_PT_WIDTH: r_pt_width <= pwdata[15:0];
                REG_PT_BINS:  r_pt_bins  <= pwdata[4:0];
                REG_Y_MIN:    r_y_min    <= pwdata[14:0];
                REG_Y_WIDTH:  r_y_width  <= pwdata[14:0];
                REG_Y_BINS:   r_y_bins   <= pwdata[4:0];
                REG_ORDERS:   r_orders   <= pwdata[3:0];
                REG_RAPIDITY: r_rap_sel  <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            REG_PT_MIN:   prdata = {16'd0, r_pt_min};
            REG_PT_WIDTH: prdata = {16'd0, r_pt_width};
            REG_PT_BINS:  prdata = {27'd0, r_pt_bins};
            REG_Y_MIN:    prdata = {17'd0, r_y_min};
            REG_Y_WIDTH:  prdata = {17'd0, r_y_width};
            REG_Y_BINS:   prdata = {27'd0, r_y_bins};
            REG_ORDERS:   prdata = {28'd0, r_orders};
            REG_RAPIDITY: prdata = {31'd0, r_rap_sel};
            default:      prdata = 32'd0;
        endcase
    end

    assign npt    = (int'(r_pt_bins) > MAX_PT_BINS) ? 9'(MAX_PT_BINS) : {4'd0, r_pt_bins};
    assign ny     = (int'(r_y_bins) > MAX_Y_BINS) ? 9'(MAX_Y_BINS) : {4'd0, r_y_bins};
    assign orders = (int'(r_orders) > MAX_ORDERS) ? 5'(MAX_ORDERS) : {1'b0, r_orders};
    assign ncols  = CW'(COLS_PER_HARMONIC * int'(orders) + BASE_COLS);

    assign o_in_ready = (r_state == S_IDLE);
    assign in_fire    = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;

    assign y_sel = r_rap_sel ? {i_true_rapidity[14], i_true_rapidity}
                             : {i_pseudorapidity[14], i_pseudorapidity};
    assign d_pt  = {1'b0, i_pt} - {1'b0, r_pt_min};
    assign d_y   = y_sel - {r_y_min[14], r_y_min};

    assign div_start  = in_fire && !i_mode;
    assign div_num[0] = d_pt[15:0];
    assign div_num[1] = d_y[15:0];
    assign div_den[0] = r_pt_width;
    assign div_den[1] = {1'b0, r_y_width};

    bfma_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    assign col_next   = r_col + CW'(1);
    assign new_harm   = (int'(col_next) == FIRST_HARM_COL)
                     || ((int'(r_col) >= FIRST_HARM_COL) && (r_sub == SUB_SIN_SQ));
    assign cor_start  = (r_state == S_WR) && (col_next != ncols) && new_harm;
    assign next_angle = r_angle + r_phi;

    bfma_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cor_start),
        .i_angle (next_angle),
        .o_done  (cor_done),
        .o_cos   (cor_cos),
        .o_sin   (cor_sin)
    );

    assign fill_hit = !r_neg && (int'(div_quo[0]) < int'(npt))
                   && (int'(div_quo[1]) < int'(ny));

    always_comb begin
        addv = 64'd0;
        if (int'(r_col) < FIRST_HARM_COL) begin
            unique case (r_col[2:0])
                3'd0:    addv = {48'd0, r_pt};
                3'd1:    addv = {32'd0, r_pt_sq};
                3'd2:    addv = {{49{r_y[14]}}, r_y};
                3'd3:    addv = {34'd0, r_y_sq};
                3'd4:    addv = {48'd0, r_et};
                default: addv = 64'd1;
            endcase
        end else begin
            unique case (r_sub)
                SUB_COS:    addv = {{(64-TRIG_W){r_c[TRIG_W-1]}}, r_c};
                SUB_SIN:    addv = {{(64-TRIG_W){r_s[TRIG_W-1]}}, r_s};
                SUB_COS_SQ: addv = {28'd0, r_c_sq};
                default:    addv = {28'd0, r_s_sq};
            endcase
        end
    end

    assign mem_addr  = r_cell_base + AW'(r_col);
    assign mem_we    = (r_state == S_CLEAR) || (r_state == S_WR);
    assign mem_waddr = (r_state == S_CLEAR) ? r_clr : mem_addr;
    assign mem_wdata = (r_state == S_CLEAR) ? 64'd0 : (mem_rdata + addv);

    bfma_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_addr),
        .o_rdata (mem_rdata)
    );

    assign n_count = (!r_mode && r_hit && (int'(ncols) > COUNT_COL) && (r_count != 32'hFFFF_FFFF))
                   ? r_count + 32'd1 : r_count;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR:  if (int'(r_clr) == DEPTH - 1) n_state = S_IDLE;
            S_IDLE:   if (in_fire) n_state = i_mode ? S_RRD : S_DIV;
            S_DIV:    if (div_done) n_state = S_CHECK;
            S_CHECK:  n_state = fill_hit ? S_RD : S_DONE;
            S_RD:     n_state = S_WR;
            S_WR: begin
                if (col_next == ncols) n_state = S_DONE;
                else if (new_harm) n_state = S_CORDIC;
                else n_state = S_RD;
            end
            S_CORDIC: if (cor_done) n_state = S_SQ;
            S_SQ:     n_state = S_RD;
            S_RRD:    n_state = r_hit ? S_RDATA : S_DONE;
            S_RDATA:  n_state = S_DONE;
            S_DONE:   if (out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_count     <= 32'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + AW'(1);
            end
            if ((r_state == S_DONE) && out_free) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pt_sq <= r_pt * r_pt;
        r_y_sq  <= 30'(30'(r_y) * 30'(r_y));
        if (in_fire) begin
            r_mode  <= i_mode;
            r_pt    <= i_pt;
            r_y     <= y_sel[14:0];
            r_phi   <= i_azimuth;
            r_et    <= i_transverse_energy;
            r_angle <= 16'd0;
            r_value <= 64'd0;
            r_col   <= '0;
            r_sub   <= SUB_COS;
            r_neg   <= d_pt[16] || d_y[15] || (r_pt_width == 16'd0) || (r_y_width == 15'd0);
            r_hit   <= (int'(i_read_pt_bin) < int'(npt)) && (int'(i_read_y_bin) < int'(ny))
                    && (int'(i_read_column) < int'(ncols));
            r_cell_base <= AW'((int'(i_read_pt_bin) * MAX_Y_BINS + int'(i_read_y_bin))
                               * CELL_COLS + int'(i_read_column));
        end
        if (r_state == S_CHECK) begin
            r_hit       <= fill_hit;
            r_cell_base <= AW'((int'(div_quo[0]) * MAX_Y_BINS + int'(div_quo[1])) * CELL_COLS);
        end
        if (r_state == S_WR) begin
            r_col <= col_next;
            if (int'(r_col) >= FIRST_HARM_COL) begin
                r_sub <= r_sub + 2'd1;
            end
            if (cor_start) begin
                r_angle <= next_angle;
                r_sub   <= SUB_COS;
            end
        end
        if (r_state == S_SQ) begin
            r_c    <= cor_cos;
            r_s    <= cor_sin;
            r_c_sq <= 36'(36'(cor_cos) * 36'(cor_cos));
            r_s_sq <= 36'(36'(cor_sin) * 36'(cor_sin));
        end
        if (r_state == S_RDATA) begin
            r_value <= mem_rdata;
        end
        if ((r_state == S_DONE) && out_free) begin
            r_out_accepted <= r_hit;
            r_out_value    <= r_value;
            r_out_total    <= n_count;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_accepted       = r_out_accepted;
    assign o_cell_value     = r_out_value;
    assign o_particle_total = r_out_total;

endmodule

// File: sim/binned_flow_moment_accumulator_tb.sv
// Self-checking testbench for the binned flow moment accumulator.
module binned_flow_moment_accumulator_tb
    import bfma_pkg::*;
();

    localparam int NPT = 16;
    localparam int NY = 16;
    localparam int NORD = 8;
    localparam int NCOL = 4 * NORD + 3;
    localparam int DRAIN_CYCLES = 400;
    localparam longint CYCLE_LIMIT = 1500000;

    typedef struct {
        logic        accepted;
        logic [63:0] cell_value;
        logic [31:0] particle_total;
    } t_result;

    typedef struct {
        logic              mode;
        logic [15:0]       pt;
        logic signed [14:0] eta;
        logic signed [14:0] rap;
        logic [15:0]       phi;
        logic [15:0]       et;
        logic [3:0]        rd_pt;
        logic [3:0]        rd_y;
        logic [5:0]        rd_col;
    } t_particle;

    class histogram_scoreboard;
        logic [63:0] cells[NPT * NY * NCOL];
        logic [31:0] count;
        logic [15:0] pt_min, pt_width;
        logic [4:0]  pt_bins, y_bins;
        logic signed [14:0] y_min;
        logic [14:0] y_width;
        logic [3:0]  orders;
        logic        rap_sel;
        t_result     pending[$];
        int          errors;

        function void clear_all();
            foreach (cells[i]) cells[i] = '0;
            count = '0;
            pt_min = 0; pt_width = 256; pt_bins = 16;
            y_min = -8192; y_width = 1024; y_bins = 16;
            orders = 8; rap_sel = 0;
            errors = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [31:0] v);
            case (idx)
                REG_PT_MIN:   pt_min = v[15:0];
                REG_PT_WIDTH: pt_width = v[15:0];
                REG_PT_BINS:  pt_bins = v[4:0];
                REG_Y_MIN:    y_min = v[14:0];
                REG_Y_WIDTH:  y_width = v[14:0];
                REG_Y_BINS:   y_bins = v[4:0];
                REG_ORDERS:   orders = v[3:0];
                REG_RAPIDITY: rap_sel = v[0];
                default: ;
            endcase
        endfunction

        function int floored_div(int num, int den);
            if (num >= 0) return num / den;
            return -((-num + den - 1) / den);
        endfunction

        function int floored_shift(int v, int k);
            return v >>> k;
        endfunction

        function void rotate(logic [15:0] ang, output int c, output int s);
            logic [16:0] sum;
            int q, z, x, y, dx, dy;
            sum = {1'b0, ang} + 17'd8192;
            q = sum[15:14];
            z = int'(sum[13:0]) - 8192;
            x = 9949;
            y = 0;
            for (int i = 0; i < CORDIC_STEPS; i++) begin
                dx = floored_shift(y, i);
                dy = floored_shift(x, i);
                if (z >= 0) begin
                    x -= dx; y += dy; z -= int'(arc_table(i));
                end else begin
                    x += dx; y -= dy; z += int'(arc_table(i));
                end
            end
            case (q)
                0: begin c = x; s = y; end
                1: begin c = -y; s = x; end
                2: begin c = -x; s = -y; end
                default: begin c = y; s = -x; end
            endcase
        endfunction

        function void note_particle(t_particle p);
            int npt, ny, nord, ncols, ix, iy, base, c, s, yv;
            logic [15:0] ang;
            t_result r;
            npt = pt_bins > NPT ? NPT : pt_bins;
            ny = y_bins > NY ? NY : y_bins;
            nord = orders > NORD ? NORD : orders;
            ncols = 4 * nord + 3;
            r.accepted = 0;
            r.cell_value = '0;
            if (p.mode) begin
                if (p.rd_pt < npt && p.rd_y < ny && p.rd_col < ncols) begin
                    r.accepted = 1;
                    r.cell_value = cells[(p.rd_pt * NY + p.rd_y) * NCOL + p.rd_col];
                end
            end else if (pt_width != 0 && y_width != 0) begin
                yv = rap_sel ? int'(p.rap) : int'(p.eta);
                ix = floored_div(int'(p.pt) - int'(pt_min), pt_width);
                iy = floored_div(yv - int'(y_min), y_width);
                if (ix >= 0 && ix < npt && iy >= 0 && iy < ny) begin
                    r.accepted = 1;
                    base = (ix * NY + iy) * NCOL;
                    cells[base] += p.pt;
                    cells[base + 1] += longint'(p.pt) * longint'(p.pt);
                    cells[base + 2] += longint'(yv);
                    if (ncols > 3) begin
                        cells[base + 3] += longint'(yv) * longint'(yv);
                        cells[base + 4] += p.et;
                        cells[base + 5] += 1;
                        cells[base + 6] += 1;
                        if (count != 32'hFFFF_FFFF) count++;
                    end
                    for (int n = 1; n < nord; n++) begin
                        ang = 16'(n * p.phi);
                        rotate(ang, c, s);
                        cells[base + 4 * n + 3] += longint'(c);
                        cells[base + 4 * n + 4] += longint'(s);
                        cells[base + 4 * n + 5] += longint'(c) * longint'(c);
                        cells[base + 4 * n + 6] += longint'(s) * longint'(s);
                    end
                end
            end
            r.particle_total = count;
            pending = {pending, r};
        endfunction

        function void check_result(t_result got);
            t_result exp_r;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result accepted=%0d value=%0d total=%0d",
                         $time, got.accepted, got.cell_value, got.particle_total);
                errors++;
                return;
            end
            exp_r = pending.pop_front();
            if (got.accepted !== exp_r.accepted) begin
                $display("%0t: accepted expected %0d actual %0d",
                         $time, exp_r.accepted, got.accepted);
                errors++;
            end
            if (got.cell_value !== exp_r.cell_value) begin
                $display("%0t: cell_value expected %0d actual %0d",
                         $time, $signed(exp_r.cell_value), $signed(got.cell_value));
                errors++;
            end
            if (got.particle_total !== exp_r.particle_total) begin
                $display("%0t: particle_total expected %0d actual %0d",
                         $time, exp_r.particle_total, got.particle_total);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_in_valid = 0;
    logic o_in_ready;
    logic i_mode = 0;
    logic [15:0] i_pt = 0;
    logic signed [14:0] i_pseudorapidity = 0;
    logic signed [14:0] i_true_rapidity = 0;
    logic [15:0] i_azimuth = 0;
    logic [15:0] i_transverse_energy = 0;
    logic [3:0] i_read_pt_bin = 0;
    logic [3:0] i_read_y_bin = 0;
    logic [5:0] i_read_column = 0;
    logic o_out_valid;
    logic i_out_ready = 0;
    logic o_accepted;
    logic signed [63:0] o_cell_value;
    logic [31:0] o_particle_total;
    logic psel = 0;
    logic penable = 0;
    logic pwrite = 0;
    logic [4:0] paddr = 0;
    logic [31:0] pwdata = 0;
    logic [31:0] prdata;
    logic pready;

    histogram_scoreboard hist = new();
    longint cycle_count = 0;
    int hold_off = 0;

    binned_flow_moment_accumulator dut (.*);

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        t_result r;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            r.accepted = o_accepted;
            r.cell_value = o_cell_value;
            r.particle_total = o_particle_total;
            hist.check_result(r);
        end
    end

    // Receiver: random stalls between beats, plus one long hold-off on request.
    initial begin
        int gap;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_off > 0) begin
                i_out_ready <= 0;
                hold_off--;
            end else if (i_out_ready && o_out_valid) begin
                gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 10);
                if (gap > 0) begin
                    i_out_ready <= 0;
                    repeat (gap - 1) @(negedge i_clk);
                    i_out_ready <= 1;
                end
            end else begin
                i_out_ready <= 1;
            end
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [31:0] v);
        @(negedge i_clk);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= v;
        @(negedge i_clk);
        penable <= 1;
        @(negedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        hist.write_reg(idx, v);
    endtask

    task automatic send_beat(t_particle p, bit no_gap);
        int gap;
        gap = no_gap ? 0 : ($urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 10));
        repeat (gap) @(negedge i_clk);
        @(negedge i_clk);
        i_in_valid <= 1;
        i_mode <= p.mode; i_pt <= p.pt; i_pseudorapidity <= p.eta;
        i_true_rapidity <= p.rap; i_azimuth <= p.phi; i_transverse_energy <= p.et;
        i_read_pt_bin <= p.rd_pt; i_read_y_bin <= p.rd_y; i_read_column <= p.rd_col;
        do @(posedge i_clk); while (!o_in_ready);
        hist.note_particle(p);
        @(negedge i_clk);
        i_in_valid <= 0;
    endtask

    function automatic t_particle random_particle();
        t_particle p;
        int pick;
        p.mode = $urandom_range(0, 3) == 0;
        pick = $urandom_range(0, 9);
        p.pt = pick < 7 ? 16'(hist.pt_min + $urandom_range(0, 4200)) : 16'($urandom);
        p.eta = pick < 7 ? 15'(hist.y_min + $urandom_range(0, 17000)) : 15'($urandom);
        p.rap = pick < 7 ? 15'(hist.y_min + $urandom_range(0, 17000)) : 15'($urandom);
        p.phi = $urandom;
        p.et = $urandom;
        p.rd_pt = $urandom;
        p.rd_y = $urandom;
        p.rd_col = $urandom_range(0, 9) == 0 ? 6'($urandom) : 6'($urandom_range(0, 34));
        return p;
    endfunction

    task automatic wait_idle();
        while (hist.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic random_phase(int n);
        for (int i = 0; i < n; i++) send_beat(random_particle(), 0);
    endtask

    initial begin
        t_particle p;
        hist.clear_all();
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;

        // Directed beats at default configuration.
        p = '{0, 16'd0, -15'sd8192, 15'sd0, 16'd0, 16'd0, 4'd0, 4'd0, 6'd0};
        send_beat(p, 1);
        p = '{0, 16'd4095, 15'sd8191, 15'h4000, 16'hFFFF, 16'hFFFF, 0, 0, 0};
        send_beat(p, 1);
        p = '{0, 16'hFFFF, 15'sd0, 15'sd0, 16'h4000, 16'd1, 0, 0, 0};
        send_beat(p, 1);
        p = '{0, 16'd100, 15'h4000, 15'sd0, 16'h8000, 16'd1, 0, 0, 0};
        send_beat(p, 1);
        p = '{0, 16'd100, 15'sd16383, 15'sd0, 16'h2000, 16'd1, 0, 0, 0};
        send_beat(p, 1);
        for (int c = 0; c < 36; c += 5) begin
            p = '{1, 0, 0, 0, 0, 0, 4'd0, 4'd0, 6'(c)};
            send_beat(p, 1);
        end
        p = '{1, 0, 0, 0, 0, 0, 4'd15, 4'd15, 6'd63};
        send_beat(p, 1);
        p = '{1, 0, 0, 0, 0, 0, 4'd15, 4'd15, 6'd34};
        send_beat(p, 1);

        // Long output stall so the block backs up on its input.
        hold_off = 400;
        random_phase(60);
        wait_idle();

        write_reg(REG_PT_MIN, 32'd1000);
        write_reg(REG_PT_WIDTH, 32'd300);
        write_reg(REG_PT_BINS, 32'd31);
        write_reg(REG_Y_MIN, 32'h4000);
        write_reg(REG_Y_WIDTH, 32'd2500);
        write_reg(REG_Y_BINS, 32'd7);
        write_reg(REG_ORDERS, 32'd15);
        write_reg(REG_RAPIDITY, 32'd1);
        random_phase(120);
        wait_idle();

        write_reg(REG_PT_MIN, 32'hFFFF);
        write_reg(REG_PT_WIDTH, 32'hFFFF);
        write_reg(REG_PT_BINS, 32'd1);
        write_reg(REG_Y_MIN, 32'h3FFF);
        write_reg(REG_Y_WIDTH, 32'h7FFF);
        write_reg(REG_Y_BINS, 32'd1);
        write_reg(REG_ORDERS, 32'd1);
        write_reg(REG_RAPIDITY, 32'd0);
        p = '{0, 16'hFFFF, 15'sd16383, 0, 16'd7, 16'd9, 0, 0, 0};
        send_beat(p, 1);
        random_phase(40);
        wait_idle();

        write_reg(REG_ORDERS, 32'd0);
        write_reg(REG_PT_MIN, 32'd0);
        write_reg(REG_PT_WIDTH, 32'd1);
        write_reg(REG_PT_BINS, 32'd16);
        write_reg(REG_Y_MIN, 32'h4000);
        write_reg(REG_Y_WIDTH, 32'd1);
        write_reg(REG_Y_BINS, 32'd16);
        random_phase(60);
        wait_idle();

        write_reg(REG_PT_WIDTH, 32'd0);
        random_phase(20);
        wait_idle();
        write_reg(REG_PT_WIDTH, 32'd256);
        write_reg(REG_Y_WIDTH, 32'd0);
        random_phase(20);
        wait_idle();
        write_reg(REG_Y_WIDTH, 32'd1024);
        write_reg(REG_Y_BINS, 32'd0);
        random_phase(15);
        wait_idle();

        write_reg(REG_PT_MIN, 32'd0);
        write_reg(REG_PT_WIDTH, 32'd256);
        write_reg(REG_PT_BINS, 32'd16);
        write_reg(REG_Y_MIN, 32'h6000);
        write_reg(REG_Y_WIDTH, 32'd1024);
        write_reg(REG_Y_BINS, 32'd16);
        write_reg(REG_ORDERS, 32'd4);
        write_reg(REG_RAPIDITY, 32'd1);
        random_phase(150);

        while (hist.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (hist.errors == 0 && hist.pending.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
